[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros used by the top level of the FM oscillator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset (needs clk_i and rst_ni in scope)
`define CFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included (needs clk_i in scope)
`define CFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[hdl/cfm_pkg.sv]
// ----------------------------------------------------------------------------
// cfm_pkg
// Shared types and constants of the cascade FM oscillator.
// ----------------------------------------------------------------------------
package cfm_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  // Output sample width on the result channel
  localparam int OUT_BITS = 16;

  // Register map
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CARRIER_STEP = 3'd0,
    REG_MOD_ONE_STEP = 3'd1,
    REG_MOD_TWO_STEP = 3'd2,
    REG_INDEX_ONE    = 3'd3,
    REG_INDEX_TWO    = 3'd4,
    REG_OUT_GAIN     = 3'd5,
    REG_SAMPLE_TOTAL = 3'd6
  } cfm_reg_e;

  // Register reset values
  localparam logic [15:0] OUT_GAIN_RST     = 16'd16384;
  localparam logic [23:0] SAMPLE_TOTAL_RST = 24'd44100;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_SINE   = 3'd1,
    OP_MUL    = 3'd2,
    OP_ADD    = 3'd3,
    OP_FINISH = 3'd4
  } cfm_op_e;

  // Operator level that an operation works on
  typedef enum logic [1:0] {
    LVL_CARRIER = 2'd0,
    LVL_MOD_ONE = 2'd1,
    LVL_MOD_TWO = 2'd2,
    LVL_GAIN    = 2'd3
  } cfm_lvl_e;

  // Command from controller to datapath
  typedef struct packed {
    logic     clear;  // restart request accepted: zero phases and counter
    cfm_op_e  op;
    cfm_lvl_e lvl;
  } cfm_cmd_t;

endpackage

[hdl/cfm_in_if.sv]
// ----------------------------------------------------------------------------
// cfm_in_if
// Request channel carrying one sample tick and its restart flag.
// ----------------------------------------------------------------------------
interface cfm_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

[hdl/cfm_out_if.sv]
// ----------------------------------------------------------------------------
// cfm_out_if
// Result channel carrying one synthesized sample.
// ----------------------------------------------------------------------------
interface cfm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cfm_pkg::OUT_BITS-1:0] sample_out;
  logic                                note_end;

  modport source (output valid, output sample_out, output note_end, input ready);
  modport sink   (input valid, input sample_out, input note_end, output ready);
endinterface

[hdl/cfm_cfg_if.sv]
// ----------------------------------------------------------------------------
// cfm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cfm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cfm_pkg::CFG_INDEX_BITS-1:0] index;
  logic [cfm_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/cfm_ctrl.sv]
// ----------------------------------------------------------------------------
// cfm_ctrl
// Sequencer: walks the shared sine table and multiplier through the three
// operators of one sample and owns the request/result handshakes.
// ----------------------------------------------------------------------------
module cfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_restart_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfm_pkg::cfm_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SIN2 = 10'b00_0000_0010,
    ST_MUL2 = 10'b00_0000_0100,
    ST_ADD1 = 10'b00_0000_1000,
    ST_SIN1 = 10'b00_0001_0000,
    ST_MUL1 = 10'b00_0010_0000,
    ST_ADD0 = 10'b00_0100_0000,
    ST_SIN0 = 10'b00_1000_0000,
    ST_MULG = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   take;
  logic   finish;

  // Result slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign take       = in_valid_i && in_ready_o;
  assign finish     = (state_q == ST_DONE) && out_free;

  // Next state and datapath command
  always_comb begin
    state_d     = state_q;
    cmd_o.clear = take && in_restart_i;
    cmd_o.op    = cfm_pkg::OP_NONE;
    cmd_o.lvl   = cfm_pkg::LVL_CARRIER;
    unique case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_SIN2;
      end
      ST_SIN2: begin
        cmd_o.op  = cfm_pkg::OP_SINE;
        cmd_o.lvl = cfm_pkg::LVL_MOD_TWO;
        state_d   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.op  = cfm_pkg::OP_MUL;
        cmd_o.lvl = cfm_pkg::LVL_MOD_TWO;
        state_d   = ST_ADD1;
      end
      ST_ADD1: begin
        cmd_o.op  = cfm_pkg::OP_ADD;
        cmd_o.lvl = cfm_pkg::LVL_MOD_ONE;
        state_d   = ST_SIN1;
      end
      ST_SIN1: begin
        cmd_o.op  = cfm_pkg::OP_SINE;
        cmd_o.lvl = cfm_pkg::LVL_MOD_ONE;
        state_d   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.op  = cfm_pkg::OP_MUL;
        cmd_o.lvl = cfm_pkg::LVL_MOD_ONE;
        state_d   = ST_ADD0;
      end
      ST_ADD0: begin
        cmd_o.op  = cfm_pkg::OP_ADD;
        cmd_o.lvl = cfm_pkg::LVL_CARRIER;
        state_d   = ST_SIN0;
      end
      ST_SIN0: begin
        cmd_o.op  = cfm_pkg::OP_SINE;
        cmd_o.lvl = cfm_pkg::LVL_CARRIER;
        state_d   = ST_MULG;
      end
      ST_MULG: begin
        cmd_o.op  = cfm_pkg::OP_MUL;
        cmd_o.lvl = cfm_pkg::LVL_GAIN;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // wait here while the previous result is still held
        if (finish) begin
          cmd_o.op = cfm_pkg::OP_FINISH;
          state_d  = take ? ST_SIN2 : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid flag: set on finish, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (finish) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/cfm_datapath.sv]
// ----------------------------------------------------------------------------
// cfm_datapath
// Phase accumulators, sample counter, quarter-wave sine table, one shared
// multiplier and the output rounding/saturation stage.
// ----------------------------------------------------------------------------
module cfm_datapath #(
  parameter int PHASE_BITS     = 24,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cfm_pkg::cfm_cmd_t                   cmd_i,
  input  logic [PHASE_BITS-1:0]               carrier_step_i,
  input  logic [PHASE_BITS-1:0]               mod_one_step_i,
  input  logic [PHASE_BITS-1:0]               mod_two_step_i,
  input  logic [15:0]                         index_one_i,
  input  logic [15:0]                         index_two_i,
  input  logic [15:0]                         out_gain_i,
  input  logic [23:0]                         sample_total_i,
  output logic signed [cfm_pkg::OUT_BITS-1:0] sample_out_o,
  output logic                                note_end_o
);

  localparam int QB   = SINE_ADDR_BITS - 2;        // quarter-wave address bits
  localparam int QLEN = 1 << QB;
  localparam int SF   = SAMPLE_BITS - 1;           // sine fraction bits
  localparam int FB   = 12 + SF;                   // fraction bits of index * sine
  localparam int PW   = 17 + SAMPLE_BITS;          // product width
  localparam int YW   = PW - 14;                   // rounded sample width
  localparam int OW   = (SAMPLE_BITS > cfm_pkg::OUT_BITS) ? SAMPLE_BITS : cfm_pkg::OUT_BITS;

  // Q30 Taylor coefficients of sin(pi/2 * x)
  localparam logic [63:0] K_A = 64'd1686629713;
  localparam logic [63:0] K_B = 64'd693598668;
  localparam logic [63:0] K_C = 64'd85569306;
  localparam logic [63:0] K_D = 64'd5026994;

  localparam logic signed [YW-1:0] Y_MAX = YW'((64'd1 << SF) - 64'd1);
  localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;

  // Quarter-wave entry, evaluated at elaboration
  function automatic logic [SF-1:0] sine_entry(input int unsigned pos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] v;
    x  = 64'(pos) << (30 - QB);
    x2 = (x * x) >> 30;
    p  = K_C - ((x2 * K_D) >> 30);
    p  = K_B - ((x2 * p) >> 30);
    p  = K_A - ((x2 * p) >> 30);
    p  = (x * p) >> 30;
    v  = (p + (64'd1 << (29 - SF))) >> (30 - SF);
    if (v > ((64'd1 << SF) - 64'd1)) v = (64'd1 << SF) - 64'd1;
    return SF'(v);
  endfunction

  // Quarter-wave table; the full-scale point (pos == QLEN) is kept apart
  localparam logic [SF-1:0] SINE_EDGE = sine_entry(QLEN);
  logic [SF-1:0] quarter_rom [QLEN];

  for (genvar k = 0; k < QLEN; k++) begin : g_rom
    assign quarter_rom[k] = sine_entry(k);
  end

  // Architectural state
  logic [PHASE_BITS-1:0] carrier_q, mod_one_q, mod_two_q;
  logic [23:0]           idx_q;

  // Work registers
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [PW-1:0]          prod_q;
  logic [PHASE_BITS-1:0]         ph_q;
  logic signed [cfm_pkg::OUT_BITS-1:0] sample_q;
  logic                          note_end_q;

  // Sine lookup with quadrant folding
  logic [PHASE_BITS-1:0]     sin_src;
  logic [SINE_ADDR_BITS-1:0] sin_addr;
  logic [1:0]                quad;
  logic [QB:0]               mpos;
  logic [SF-1:0]             mag;
  logic signed [SAMPLE_BITS-1:0] sin_val;

  assign sin_src  = (cmd_i.lvl == cfm_pkg::LVL_MOD_TWO) ? mod_two_q : ph_q;
  assign sin_addr = sin_src[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad     = sin_addr[SINE_ADDR_BITS-1 -: 2];
  assign mpos     = quad[0] ? ((QB+1)'(QLEN) - {1'b0, sin_addr[QB-1:0]})
                            : {1'b0, sin_addr[QB-1:0]};
  assign mag      = mpos[QB] ? SINE_EDGE : quarter_rom[mpos[QB-1:0]];
  assign sin_val  = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Shared multiplier operand
  logic signed [16:0] mul_a;
  always_comb begin
    unique case (cmd_i.lvl)
      cfm_pkg::LVL_MOD_TWO: mul_a = $signed({1'b0, index_two_i});
      cfm_pkg::LVL_MOD_ONE: mul_a = $signed({1'b0, index_one_i});
      cfm_pkg::LVL_CARRIER,
      cfm_pkg::LVL_GAIN:    mul_a = $signed({1'b0, out_gain_i});
      default:              mul_a = $signed({1'b0, out_gain_i});
    endcase
  end

  // Modulation offset: product rescaled to phase fraction bits
  logic [PHASE_BITS-1:0] offset;
  if (FB >= PHASE_BITS) begin : g_off_down
    assign offset = prod_q[FB-PHASE_BITS +: PHASE_BITS];
  end else begin : g_off_up
    assign offset = {prod_q[FB-1:0], {(PHASE_BITS-FB){1'b0}}};
  end

  logic [PHASE_BITS-1:0] add_base;
  assign add_base = (cmd_i.lvl == cfm_pkg::LVL_MOD_ONE) ? mod_one_q : carrier_q;

  // Output rounding (round half up) and saturation
  logic signed [PW:0]             round_sum;
  logic signed [YW-1:0]           y;
  logic signed [SAMPLE_BITS-1:0]  sat;
  logic signed [OW-1:0]           sat_ext;

  assign round_sum = $signed({prod_q[PW-1], prod_q}) + $signed((PW+1)'(16384));
  assign y         = $signed(round_sum[PW:15]);

  always_comb begin
    if (y > Y_MAX)      sat = Y_MAX[SAMPLE_BITS-1:0];
    else if (y < Y_MIN) sat = Y_MIN[SAMPLE_BITS-1:0];
    else                sat = y[SAMPLE_BITS-1:0];
  end

  assign sat_ext = OW'(sat);

  // Note end detection
  logic [24:0] idx_inc;
  logic        last;
  assign idx_inc = {1'b0, idx_q} + 25'd1;
  assign last    = idx_inc >= {1'b0, sample_total_i};

  // Work registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cfm_pkg::OP_SINE) s_q <= sin_val;
    if (cmd_i.op == cfm_pkg::OP_MUL)  prod_q <= mul_a * s_q;
    if (cmd_i.op == cfm_pkg::OP_ADD)  ph_q <= add_base + offset;
    if (cmd_i.op == cfm_pkg::OP_FINISH) begin
      sample_q   <= sat_ext[cfm_pkg::OUT_BITS-1:0];
      note_end_q <= last;
    end
  end

  // Phases and counter: advance after a sample, restart overrides
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q <= '0;
      mod_one_q <= '0;
      mod_two_q <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        carrier_q <= '0;
        mod_one_q <= '0;
        mod_two_q <= '0;
        idx_q     <= '0;
      end else if (cmd_i.op == cfm_pkg::OP_FINISH) begin
        carrier_q <= carrier_q + carrier_step_i;
        mod_one_q <= mod_one_q + mod_one_step_i;
        mod_two_q <= mod_two_q + mod_two_step_i;
        idx_q     <= last ? '0 : idx_inc[23:0];
      end
    end
  end

  assign sample_out_o = sample_q;
  assign note_end_o   = note_end_q;

endmodule

[hdl/cascade_fm_oscillator.sv]
// ----------------------------------------------------------------------------
// cascade_fm_oscillator
// Three-operator cascade FM oscillator: gain * sin(C + I1*sin(M1 + I2*sin(M2)))
// per sample tick, with a shared sine table and multiplier.
//
//   channel  dir  payload                  notes
//   in_i     in   restart                  one request per audio sample
//   out_o    out  sample_out, note_end     one result per request
//   cfg_i    in   index, data              register write, always ready
//
// An accepted request walks the sine, multiply and add steps of the three
// operators, then a final step writes its result to the output register;
// the next request is taken in the cycle the result is written. The single
// sine table and multiplier are visited three times per sample.
// A held result stalls the final step of the sample in flight, and no new
// request is accepted until that step completes. No memory clearing pass
// after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cascade_fm_oscillator #(
  parameter int PHASE_BITS     = 24,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfm_in_if.sink    in_i,
  cfm_out_if.source out_o,
  cfm_cfg_if.sink   cfg_i
);

  // Configuration registers
  logic [23:0] carrier_step_q, mod_one_step_q, mod_two_step_q, sample_total_q;
  logic [15:0] index_one_q, index_two_q, out_gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_step_q <= '0;
      mod_one_step_q <= '0;
      mod_two_step_q <= '0;
      index_one_q    <= '0;
      index_two_q    <= '0;
      out_gain_q     <= cfm_pkg::OUT_GAIN_RST;
      sample_total_q <= cfm_pkg::SAMPLE_TOTAL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        cfm_pkg::REG_CARRIER_STEP: carrier_step_q <= cfg_i.data;
        cfm_pkg::REG_MOD_ONE_STEP: mod_one_step_q <= cfg_i.data;
        cfm_pkg::REG_MOD_TWO_STEP: mod_two_step_q <= cfg_i.data;
        cfm_pkg::REG_INDEX_ONE:    index_one_q    <= cfg_i.data[15:0];
        cfm_pkg::REG_INDEX_TWO:    index_two_q    <= cfg_i.data[15:0];
        cfm_pkg::REG_OUT_GAIN:     out_gain_q     <= cfg_i.data[15:0];
        cfm_pkg::REG_SAMPLE_TOTAL: sample_total_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Controller
  cfm_pkg::cfm_cmd_t cmd;
  logic              out_valid;

  cfm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd)
  );

  assign out_o.valid = out_valid;

  // Datapath
  cfm_datapath #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .carrier_step_i (PHASE_BITS'(carrier_step_q)),
    .mod_one_step_i (PHASE_BITS'(mod_one_step_q)),
    .mod_two_step_i (PHASE_BITS'(mod_two_step_q)),
    .index_one_i    (index_one_q),
    .index_two_i    (index_two_q),
    .out_gain_i     (out_gain_q),
    .sample_total_i (sample_total_q),
    .sample_out_o   (out_o.sample_out),
    .note_end_o     (out_o.note_end)
  );

  // Handshake terms for the checks below
  logic in_take;
  logic fin_step;
  logic out_free;
  assign in_take  = in_i.valid && in_i.ready;
  assign fin_step = (cmd.op == cfm_pkg::OP_FINISH);
  assign out_free = !out_valid || out_o.ready;

  // A result only appears right after the finishing step
  `CFM_ASSERT(a_valid_from_finish, $rose(out_valid) |-> $past(fin_step), "valid without finish")
  // One sample occupies the datapath for several cycles
  `CFM_ASSERT(a_no_back_to_back, in_take |=> !in_take, "request accepted in consecutive cycles")
  // Finishing never overwrites a result that is still held
  `CFM_ASSERT_ALWAYS(a_finish_slot_free, fin_step |-> out_free, "finish into an occupied slot")

endmodule
